### rtl/core/decoupled_sector_cache_lookup_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decoupled sector cache lookup
// Shared checking shorthands, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef DECOUPLED_SECTOR_CACHE_LOOKUP_DEFINES_SVH
`define DECOUPLED_SECTOR_CACHE_LOOKUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DSCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dscl_pkg.sv
// ---------------------------------------------------------------------------
// dscl_pkg
// Shared constants, codes and status types of the sector cache lookup.
// ---------------------------------------------------------------------------
package dscl_pkg;

	// default address split
	localparam int DEF_OFFSET_BITS    = 5;
	localparam int DEF_SET_BITS       = 6;
	localparam int DEF_BLOCK_SEL_BITS = 2;
	localparam int DEF_TAG_SEL_BITS   = 2;

	localparam int ADDR_W = 32;
	localparam int MISS_W = 2;
	localparam int WB_W   = 3;
	localparam logic [WB_W-1:0] WB_MAX = 3'd7;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// miss classification
	localparam logic [MISS_W-1:0] MISS_NONE   = 2'd0;
	localparam logic [MISS_W-1:0] MISS_BLOCK  = 2'd1;
	localparam logic [MISS_W-1:0] MISS_SECTOR = 2'd2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

### rtl/core/dscl_front.sv
// ---------------------------------------------------------------------------
// dscl_front
// Accepts items, splits the address into tag, tag select, set and block
// select, and hands the decoded item to the queue.
// ---------------------------------------------------------------------------
module dscl_front #(
	parameter int OFFSET_BITS    = dscl_pkg::DEF_OFFSET_BITS,
	parameter int SET_BITS       = dscl_pkg::DEF_SET_BITS,
	parameter int BLOCK_SEL_BITS = dscl_pkg::DEF_BLOCK_SEL_BITS,
	parameter int TAG_SEL_BITS   = dscl_pkg::DEF_TAG_SEL_BITS,
	parameter int ITEM_W         = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        cmd,
	input  logic [dscl_pkg::ADDR_W-1:0] address,
	input  dscl_pkg::q_stat_t           q_stat,
	input  dscl_pkg::back_stat_t        bk_stat,
	output logic                        busy,
	output logic                        push,
	output logic [ITEM_W-1:0]           push_data
);

	localparam int NB        = 1 << BLOCK_SEL_BITS;
	localparam int NT        = 1 << TAG_SEL_BITS;
	localparam int BSW       = (BLOCK_SEL_BITS > 0) ? BLOCK_SEL_BITS : 1;
	localparam int TSW       = (TAG_SEL_BITS > 0) ? TAG_SEL_BITS : 1;
	localparam int TAG_SHIFT = OFFSET_BITS + BLOCK_SEL_BITS + SET_BITS + TAG_SEL_BITS;
	localparam int TAG_W     = dscl_pkg::ADDR_W - TAG_SHIFT;

	logic              accept;
	logic [BSW-1:0]    bsel;
	logic [SET_BITS-1:0] set_idx;
	logic [TSW-1:0]    tsel;
	logic [TAG_W-1:0]  tag;
	logic              vld_s1;
	logic [ITEM_W-1:0] item_s1;

	// address split
	assign bsel    = BSW'((address >> OFFSET_BITS) & dscl_pkg::ADDR_W'(NB - 1));
	assign set_idx = SET_BITS'(address >> (OFFSET_BITS + BLOCK_SEL_BITS));
	assign tsel    = TSW'((address >> (OFFSET_BITS + BLOCK_SEL_BITS + SET_BITS))
		& dscl_pkg::ADDR_W'(NT - 1));
	assign tag     = TAG_W'(address >> TAG_SHIFT);

	// handshake: stage can refill in the cycle it drains
	assign push   = vld_s1 && !q_stat.full;
	assign busy   = (vld_s1 && q_stat.full) || bk_stat.clearing;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// decoded item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= {cmd, tag, tsel, set_idx, bsel};
		end
	end

	assign push_data = item_s1;

endmodule

### rtl/core/dscl_queue.sv
// ---------------------------------------------------------------------------
// dscl_queue
// Short FIFO of decoded items between the front and the back.
// ---------------------------------------------------------------------------
module dscl_queue #(
	parameter int DATA_W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data,
	output dscl_pkg::q_stat_t stat
);

	logic [DATA_W-1:0]           slot_q [dscl_pkg::QUEUE_DEPTH];
	logic [dscl_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dscl_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dscl_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign stat.full  = (cnt_q == dscl_pkg::QCNT_W'(dscl_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_data  = slot_q[rd_ptr_q];

	// pointers and fill count; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/dscl_back.sv
// ---------------------------------------------------------------------------
// dscl_back
// Per-set state memory and the lookup / install / evict sequencer. One set
// row holds all address tags and the status of all data blocks of the set.
// ---------------------------------------------------------------------------
module dscl_back #(
	parameter int OFFSET_BITS    = dscl_pkg::DEF_OFFSET_BITS,
	parameter int SET_BITS       = dscl_pkg::DEF_SET_BITS,
	parameter int BLOCK_SEL_BITS = dscl_pkg::DEF_BLOCK_SEL_BITS,
	parameter int TAG_SEL_BITS   = dscl_pkg::DEF_TAG_SEL_BITS,
	parameter int ITEM_W         = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dscl_pkg::q_stat_t           q_stat,
	input  logic [ITEM_W-1:0]           head_data,
	output logic                        pop,
	output dscl_pkg::back_stat_t        stat,
	output logic                        done,
	output logic                        hit,
	output logic [dscl_pkg::MISS_W-1:0] miss_kind,
	output logic [dscl_pkg::WB_W-1:0]   writebacks
);

	localparam int NB        = 1 << BLOCK_SEL_BITS;
	localparam int NT        = 1 << TAG_SEL_BITS;
	localparam int NUM_SETS  = 1 << SET_BITS;
	localparam int BSW       = (BLOCK_SEL_BITS > 0) ? BLOCK_SEL_BITS : 1;
	localparam int TSW       = (TAG_SEL_BITS > 0) ? TAG_SEL_BITS : 1;
	localparam int TAG_SHIFT = OFFSET_BITS + BLOCK_SEL_BITS + SET_BITS + TAG_SEL_BITS;
	localparam int TAG_W     = dscl_pkg::ADDR_W - TAG_SHIFT;
	localparam int ROW_W     = NT * TAG_W + NB * (2 + TSW);
	localparam int WBC_W     = BLOCK_SEL_BITS + 3;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} bk_state_t;

	bk_state_t state_q;
	bk_state_t state_d;

	logic [SET_BITS-1:0] clr_cnt_q;
	logic [ROW_W-1:0]    row_mem [NUM_SETS];
	logic [ROW_W-1:0]    rd_row_q;
	logic [ITEM_W-1:0]   itm_q;

	logic                mem_we;
	logic [SET_BITS-1:0] mem_wa;
	logic [ROW_W-1:0]    mem_wd;
	logic [SET_BITS-1:0] rd_addr;

	// item fields
	logic                it_cmd;
	logic [TAG_W-1:0]    it_tag;
	logic [TSW-1:0]      it_tsel;
	logic [SET_BITS-1:0] it_set;
	logic [BSW-1:0]      it_bsel;

	// current and next row contents
	logic [NT-1:0][TAG_W-1:0] tags_c;
	logic [NT-1:0][TAG_W-1:0] n_tags;
	logic [NB-1:0]            vld_c;
	logic [NB-1:0]            drt_c;
	logic [NB-1:0]            n_vld;
	logic [NB-1:0]            n_drt;
	logic [NB-1:0][TSW-1:0]   own_c;
	logic [NB-1:0][TSW-1:0]   n_own;

	logic                        tag_ok;
	logic                        hit_c;
	logic [dscl_pkg::MISS_W-1:0] kind_c;
	logic [WBC_W-1:0]            wb_c;
	logic [dscl_pkg::WB_W-1:0]   wb_sat;

	logic                        done_q;
	logic                        hit_q;
	logic [dscl_pkg::MISS_W-1:0] kind_q;
	logic [dscl_pkg::WB_W-1:0]   wb_q;

	assign {it_cmd, it_tag, it_tsel, it_set, it_bsel} = itm_q;
	assign {tags_c, vld_c, drt_c, own_c}              = rd_row_q;

	assign pop            = (state_q == ST_IDLE) && !q_stat.empty;
	assign stat.clearing  = (state_q == ST_CLEAR);
	assign rd_addr        = head_data[SET_BITS+BSW-1:BSW];

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == {SET_BITS{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_LOOK);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// lookup, eviction and install on the fetched row
	always_comb begin
		n_tags = tags_c;
		n_vld  = vld_c;
		n_drt  = drt_c;
		n_own  = own_c;
		wb_c   = '0;
		hit_c  = 1'b0;
		kind_c = dscl_pkg::MISS_NONE;
		tag_ok = (tags_c[it_tsel] == it_tag);
		if (vld_c[it_bsel] && tag_ok && (own_c[it_bsel] == it_tsel)) begin
			hit_c = 1'b1;
			if (it_cmd == dscl_pkg::CMD_WRITE) begin
				n_drt[it_bsel] = 1'b1;
			end
		end else begin
			kind_c = (|vld_c) ? dscl_pkg::MISS_BLOCK : dscl_pkg::MISS_SECTOR;
			if (!vld_c[it_bsel] && tag_ok) begin
				// tag already present, block free: plain install
				n_vld[it_bsel] = 1'b1;
				n_own[it_bsel] = it_tsel;
				if (it_cmd == dscl_pkg::CMD_WRITE) begin
					n_drt[it_bsel] = 1'b1;
				end
			end else begin
				// tag replaced: drop every block that the old tag owned
				if (!tag_ok) begin
					for (int i = 0; i < NB; i++) begin
						if (own_c[i] == it_tsel) begin
							wb_c     = wb_c + WBC_W'(drt_c[i]);
							n_vld[i] = 1'b0;
							n_drt[i] = 1'b0;
							n_own[i] = '0;
						end
					end
				end
				// target still dirty under another owner
				if (n_drt[it_bsel]) begin
					wb_c = wb_c + 1'b1;
				end
				n_tags[it_tsel] = it_tag;
				n_vld[it_bsel]  = 1'b1;
				n_own[it_bsel]  = it_tsel;
				n_drt[it_bsel]  = (it_cmd == dscl_pkg::CMD_WRITE);
			end
		end
	end

	assign wb_sat = (wb_c > WBC_W'(dscl_pkg::WB_MAX)) ? dscl_pkg::WB_MAX
		: wb_c[dscl_pkg::WB_W-1:0];

	// single write port: clearing sweep or row update
	always_comb begin
		mem_we = 1'b0;
		mem_wa = it_set;
		mem_wd = {n_tags, n_vld, n_drt, n_own};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else if (state_q == ST_LOOK) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_wa] <= mem_wd;
		end
		rd_row_q <= row_mem[rd_addr];
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			itm_q <= head_data;
		end
		if (state_q == ST_LOOK) begin
			hit_q  <= hit_c;
			kind_q <= kind_c;
			wb_q   <= wb_sat;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign miss_kind  = kind_q;
	assign writebacks = wb_q;

endmodule

### rtl/core/decoupled_sector_cache_lookup.sv
// ---------------------------------------------------------------------------
// decoupled_sector_cache_lookup
// Sector cache lookup with a decoding front, an item queue and a per-set
// read-modify-write back end.
// ---------------------------------------------------------------------------
// Usage:
//   Present cmd and address with start high; the item is taken at a rising
//   edge where start is high and busy is low. busy rises only when the front
//   register and the two-entry queue are both occupied, or during the
//   clearing sweep.
//   Each item gives one result: done is high for one cycle with hit,
//   miss_kind and writebacks valid. The receiver cannot stall; results are
//   produced in item order.
//   With the queue empty, an accepted item passes the front register, the
//   queue slot and the back end's item and row registers; the lookup state
//   then registers done and the result. The back end takes a new item only
//   when done with the last (row read in one cycle, update written in the next).
//   Reset: all control returns to its initial state and the set memory is
//   cleared by a sweep of one row per cycle over all 2^SET_BITS rows (64
//   with the default split); busy stays high until the sweep is complete.
// ---------------------------------------------------------------------------
`include "decoupled_sector_cache_lookup_defines.svh"

module decoupled_sector_cache_lookup #(
	parameter int OFFSET_BITS    = dscl_pkg::DEF_OFFSET_BITS,
	parameter int SET_BITS       = dscl_pkg::DEF_SET_BITS,
	parameter int BLOCK_SEL_BITS = dscl_pkg::DEF_BLOCK_SEL_BITS,
	parameter int TAG_SEL_BITS   = dscl_pkg::DEF_TAG_SEL_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [dscl_pkg::ADDR_W-1:0] address,
	output logic                        done,
	output logic                        hit,
	output logic [dscl_pkg::MISS_W-1:0] miss_kind,
	output logic [dscl_pkg::WB_W-1:0]   writebacks
);

	localparam int BSW       = (BLOCK_SEL_BITS > 0) ? BLOCK_SEL_BITS : 1;
	localparam int TSW       = (TAG_SEL_BITS > 0) ? TAG_SEL_BITS : 1;
	localparam int TAG_SHIFT = OFFSET_BITS + BLOCK_SEL_BITS + SET_BITS + TAG_SEL_BITS;
	localparam int TAG_W     = dscl_pkg::ADDR_W - TAG_SHIFT;
	localparam int ITEM_W    = 1 + TAG_W + TSW + SET_BITS + BSW;

	dscl_pkg::q_stat_t    q_stat;
	dscl_pkg::back_stat_t bk_stat;
	logic                 push;
	logic [ITEM_W-1:0]    push_data;
	logic                 pop;
	logic [ITEM_W-1:0]    head_data;
	logic                 res_ok;

	dscl_front #(
		.OFFSET_BITS    (OFFSET_BITS),
		.SET_BITS       (SET_BITS),
		.BLOCK_SEL_BITS (BLOCK_SEL_BITS),
		.TAG_SEL_BITS   (TAG_SEL_BITS),
		.ITEM_W         (ITEM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.address   (address),
		.q_stat    (q_stat),
		.bk_stat   (bk_stat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	dscl_queue #(
		.DATA_W (ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.stat      (q_stat)
	);

	dscl_back #(
		.OFFSET_BITS    (OFFSET_BITS),
		.SET_BITS       (SET_BITS),
		.BLOCK_SEL_BITS (BLOCK_SEL_BITS),
		.TAG_SEL_BITS   (TAG_SEL_BITS),
		.ITEM_W         (ITEM_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_data  (head_data),
		.pop        (pop),
		.stat       (bk_stat),
		.done       (done),
		.hit        (hit),
		.miss_kind  (miss_kind),
		.writebacks (writebacks)
	);

	// result fields agree: a hit writes nothing back, a miss is classified
	assign res_ok = (hit && miss_kind == dscl_pkg::MISS_NONE && writebacks == '0)
		|| (!hit && (miss_kind == dscl_pkg::MISS_BLOCK
		|| miss_kind == dscl_pkg::MISS_SECTOR));

	// result code consistency
	`DSCL_ASSERT_SAME(a_result_code, clk, arst_n, done, res_ok, "inconsistent result code")
	// back end fetches the next row before it can give another result
	`DSCL_ASSERT_NEXT(a_done_spacing, clk, arst_n, done, !done, "results closer than two cycles")
	// front never pushes into a full queue
	`DSCL_ASSERT_SAME(a_no_overflow, clk, arst_n, push, !q_stat.full, "push into full queue")
	// no item is taken while the set memory is being cleared
	`DSCL_ASSERT_SAME(a_clear_busy, clk, arst_n, bk_stat.clearing, busy, "not busy while clearing")

endmodule
